/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif

`endif

/* design/rpn_pkg.sv */
package rpn_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned DepthW  = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ActW    = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned PcW     = 5;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_DIV    = 3'd4,
    ACT_FINISH = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    U_IDLE,
    U_PUSH_CHK,
    U_PUSH_EMIT,
    U_OP_CHK,
    U_RD_TOP,
    U_RD_NEXT,
    U_LD_A,
    U_ALU,
    U_DIV_CHK,
    U_DIV_WAIT,
    U_DIV_FIN,
    U_OP_EMIT,
    U_ERR_RD,
    U_ERR_LD,
    U_ERR_EMIT,
    U_FIN_CHK,
    U_FIN_RD,
    U_FIN_EMIT,
    U_FIN_EMPTY
  } uop_e;

  // J_FLAG: target if flag else next; J_FLAG_IDLE: target if flag else idle
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_FLAG,
    J_FLAG_IDLE,
    J_DISPATCH
  } jump_e;

  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PC_IDLE      = 5'd0;
  localparam pc_t PC_PUSH      = 5'd1;
  localparam pc_t PC_PUSH_EMIT = 5'd2;
  localparam pc_t PC_OP        = 5'd3;
  localparam pc_t PC_RD_TOP    = 5'd4;
  localparam pc_t PC_RD_NEXT   = 5'd5;
  localparam pc_t PC_LD_A      = 5'd6;
  localparam pc_t PC_ALU       = 5'd7;
  localparam pc_t PC_DIV       = 5'd8;
  localparam pc_t PC_DIV_WAIT  = 5'd9;
  localparam pc_t PC_DIV_FIN   = 5'd10;
  localparam pc_t PC_OP_EMIT   = 5'd11;
  localparam pc_t PC_ERR_RD    = 5'd12;
  localparam pc_t PC_ERR_LD    = 5'd13;
  localparam pc_t PC_ERR_EMIT  = 5'd14;
  localparam pc_t PC_FIN       = 5'd15;
  localparam pc_t PC_FIN_RD    = 5'd16;
  localparam pc_t PC_FIN_EMIT  = 5'd17;
  localparam pc_t PC_FIN_EMPTY = 5'd18;

  typedef struct packed {
    uop_e  op;
    jump_e jump;
    pc_t   target;
  } uword_t;

  // microcode store
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:      w = '{U_IDLE,      J_DISPATCH,  PC_IDLE};
      PC_PUSH:      w = '{U_PUSH_CHK,  J_FLAG,      PC_ERR_RD};
      PC_PUSH_EMIT: w = '{U_PUSH_EMIT, J_GOTO,      PC_IDLE};
      PC_OP:        w = '{U_OP_CHK,    J_FLAG,      PC_ERR_RD};
      PC_RD_TOP:    w = '{U_RD_TOP,    J_NEXT,      PC_IDLE};
      PC_RD_NEXT:   w = '{U_RD_NEXT,   J_NEXT,      PC_IDLE};
      PC_LD_A:      w = '{U_LD_A,      J_FLAG,      PC_DIV};
      PC_ALU:       w = '{U_ALU,       J_GOTO,      PC_OP_EMIT};
      PC_DIV:       w = '{U_DIV_CHK,   J_FLAG,      PC_ERR_EMIT};
      PC_DIV_WAIT:  w = '{U_DIV_WAIT,  J_FLAG,      PC_DIV_WAIT};
      PC_DIV_FIN:   w = '{U_DIV_FIN,   J_NEXT,      PC_IDLE};
      PC_OP_EMIT:   w = '{U_OP_EMIT,   J_GOTO,      PC_IDLE};
      PC_ERR_RD:    w = '{U_ERR_RD,    J_NEXT,      PC_IDLE};
      PC_ERR_LD:    w = '{U_ERR_LD,    J_NEXT,      PC_IDLE};
      PC_ERR_EMIT:  w = '{U_ERR_EMIT,  J_GOTO,      PC_IDLE};
      PC_FIN:       w = '{U_FIN_CHK,   J_FLAG,      PC_FIN_EMPTY};
      PC_FIN_RD:    w = '{U_FIN_RD,    J_NEXT,      PC_IDLE};
      PC_FIN_EMIT:  w = '{U_FIN_EMIT,  J_FLAG_IDLE, PC_FIN_RD};
      PC_FIN_EMPTY: w = '{U_FIN_EMPTY, J_GOTO,      PC_IDLE};
      default:      w = '{U_IDLE,      J_GOTO,      PC_IDLE};
    endcase
    return w;
  endfunction

  // entry point for each action, unknown actions fall back to idle
  function automatic pc_t dispatch(input logic [ActW-1:0] act);
    pc_t pc;
    unique case (act) inside
      ACT_PUSH:                           pc = PC_PUSH;
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: pc = PC_OP;
      ACT_FINISH:                         pc = PC_FIN;
      default:                            pc = PC_IDLE;
    endcase
    return pc;
  endfunction

endpackage

/* design/rpn_div.sv */
module rpn_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rpn_pkg::DataW-1:0] dividend_i,
  input  logic [rpn_pkg::DataW-1:0] divisor_i,
  output logic [rpn_pkg::DataW-1:0] quotient_o,
  output logic                      busy_o
);
  import rpn_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = !diff[DataW];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      // work on magnitudes, sign fixed up at the end
      busy_d = 1'b1;
      cnt_d  = CntW'(DataW - 1);
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      quo_d  = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dsr_d  = divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[DataW-1:0] : shifted[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign busy_o     = busy_q;

endmodule

/* design/rpn_stack_calculator.sv */
// channel   dir  tvalid/tready  tdata (low bit up)                    tuser    tlast
// s_axis    in   request        operand[31:0]                        action   -
// m_axis    out  request        result_value[31:0], stack_depth[4:0] status   last
//
// one item at a time under a microcoded sequencer with a stack memory of one write and one read port
// push: check, emit; arithmetic: check, read two entries, compute (radix-2 divider), emit
// finish reads and emits each entry in turn, the stack memory giving one entry per read step
// a result step waits while the output register is full and not taken
// reset empties the stack at once, the memory itself is not cleared
`include "assert_macros.svh"

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rpn_pkg::InDataW-1:0]  s_axis_tdata_i,  // operand
  input  logic [rpn_pkg::ActW-1:0]     s_axis_tuser_i,  // action
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [rpn_pkg::OutDataW-1:0] m_axis_tdata_o,  // result_value, stack_depth, zero pad
  output logic [rpn_pkg::StatusW-1:0]  m_axis_tuser_o,  // status
  output logic                         m_axis_tlast_o
);
  import rpn_pkg::*;

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);

  // sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   flag;
  logic   stall;

  // datapath
  logic [ActW-1:0]    act_q, act_d;
  logic [DataW-1:0]   opnd_q, opnd_d;
  logic [SpW-1:0]     sp_q, sp_d;
  logic [DataW-1:0]   a_q, a_d;
  logic [DataW-1:0]   b_q, b_d;
  logic [DataW-1:0]   r_q, r_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [SpW-1:0]     sp_m1, sp_m2;
  logic [DataW-1:0]   prod;
  logic               full, under, more;

  // stack memory
  logic [DataW-1:0] mem [STACK_DEPTH];
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] rd_q;

  // divider
  logic             div_start;
  logic [DataW-1:0] div_quo;
  logic             div_busy;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_value_q, out_value_d;
  logic [DepthW-1:0]  out_depth_q, out_depth_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic               out_last_q, out_last_d;
  logic               out_free;
  logic               emit;

  assign uw       = ucode(pc_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign sp_m1    = sp_q - SpW'(1);
  assign sp_m2    = sp_q - SpW'(2);
  assign full     = (sp_q == SpW'(STACK_DEPTH));
  assign under    = (sp_q < SpW'(2));
  assign more     = (idx_q != sp_m1[AddrW-1:0]);
  assign prod     = a_q * b_q;

  assign s_axis_tready_o = (uw.op == U_IDLE);

  // stall and jump flag of the current step
  always_comb begin
    stall = 1'b0;
    flag  = 1'b0;
    unique case (uw.op) inside
      U_IDLE:      stall = !s_axis_tvalid_i;
      U_PUSH_CHK:  flag = full;
      U_OP_CHK:    flag = under;
      U_LD_A:      flag = (act_q == ACT_DIV);
      U_DIV_CHK:   flag = (b_q == '0);
      U_DIV_WAIT:  flag = div_busy;
      U_FIN_CHK:   flag = (sp_q == '0);
      U_FIN_EMIT: begin
        flag  = more;
        stall = !out_free;
      end
      U_PUSH_EMIT, U_OP_EMIT, U_ERR_EMIT, U_FIN_EMPTY: stall = !out_free;
      default: begin
        stall = 1'b0;
        flag  = 1'b0;
      end
    endcase
  end

  // next step
  always_comb begin
    pc_d = pc_q;
    if (!stall) begin
      unique case (uw.jump)
        J_NEXT:      pc_d = pc_q + 1'b1;
        J_GOTO:      pc_d = uw.target;
        J_FLAG:      pc_d = flag ? uw.target : pc_q + 1'b1;
        J_FLAG_IDLE: pc_d = flag ? uw.target : PC_IDLE;
        J_DISPATCH:  pc_d = dispatch(s_axis_tuser_i);
        default:     pc_d = PC_IDLE;
      endcase
    end
  end

  // datapath control
  always_comb begin
    act_d        = act_q;
    opnd_d       = opnd_q;
    sp_d         = sp_q;
    a_d          = a_q;
    b_d          = b_q;
    r_d          = r_q;
    status_d     = status_q;
    idx_d        = idx_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = sp_q[AddrW-1:0];
    mem_raddr    = sp_m1[AddrW-1:0];
    mem_wdata    = opnd_q;
    div_start    = 1'b0;
    emit         = 1'b0;
    out_value_d  = out_value_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (!stall) begin
      unique case (uw.op)
        U_IDLE: begin
          act_d  = s_axis_tuser_i;
          opnd_d = s_axis_tdata_i;
        end
        U_PUSH_CHK: status_d = full ? ST_OVER : ST_OK;
        U_PUSH_EMIT: begin
          mem_we       = 1'b1;
          sp_d         = sp_q + 1'b1;
          emit         = 1'b1;
          out_value_d  = opnd_q;
          out_depth_d  = DepthW'(sp_q + 1'b1);
          out_status_d = ST_OK;
          out_last_d   = 1'b1;
        end
        U_OP_CHK: status_d = under ? ST_UNDER : ST_OK;
        U_RD_TOP: mem_re = 1'b1;
        U_RD_NEXT: begin
          b_d       = rd_q;
          mem_re    = 1'b1;
          mem_raddr = sp_m2[AddrW-1:0];
        end
        U_LD_A: a_d = rd_q;
        U_ALU: begin
          case (act_q)
            ACT_ADD: r_d = a_q + b_q;
            ACT_SUB: r_d = a_q - b_q;
            default: r_d = prod;
          endcase
        end
        U_DIV_CHK: begin
          if (b_q == '0) begin
            status_d = ST_DIVZERO;
          end else begin
            div_start = 1'b1;
          end
        end
        U_DIV_WAIT: r_d = r_q;
        U_DIV_FIN: r_d = div_quo;
        U_OP_EMIT: begin
          // result replaces the next entry, the top goes away
          mem_we       = 1'b1;
          mem_waddr    = sp_m2[AddrW-1:0];
          mem_wdata    = r_q;
          sp_d         = sp_m1;
          emit         = 1'b1;
          out_value_d  = r_q;
          out_depth_d  = DepthW'(sp_m1);
          out_status_d = ST_OK;
          out_last_d   = 1'b1;
        end
        U_ERR_RD: mem_re = 1'b1;
        U_ERR_LD: b_d = (sp_q == '0) ? '0 : rd_q;
        U_ERR_EMIT: begin
          emit         = 1'b1;
          out_value_d  = b_q;
          out_depth_d  = DepthW'(sp_q);
          out_status_d = status_q;
          out_last_d   = 1'b1;
        end
        U_FIN_CHK: idx_d = '0;
        U_FIN_RD: begin
          mem_re    = 1'b1;
          mem_raddr = idx_q;
        end
        U_FIN_EMIT: begin
          emit         = 1'b1;
          out_value_d  = rd_q;
          out_depth_d  = '0;
          out_status_d = ST_OK;
          out_last_d   = !more;
          idx_d        = idx_q + 1'b1;
          if (!more) begin
            sp_d = '0;
          end
        end
        U_FIN_EMPTY: begin
          emit         = 1'b1;
          out_value_d  = '0;
          out_depth_d  = '0;
          out_status_d = ST_EMPTY;
          out_last_d   = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign out_valid_d = emit | (out_valid_q & !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    opnd_q       <= opnd_d;
    a_q          <= a_d;
    b_q          <= b_d;
    r_q          <= r_d;
    status_q     <= status_d;
    idx_q        <= idx_d;
    out_value_q  <= out_value_d;
    out_depth_q  <= out_depth_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .quotient_o (div_quo),
    .busy_o     (div_busy)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - DataW - DepthW)'(0), out_depth_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // a known action taken in idle leaves idle on the next cycle
  `ASSERT_DEF(a_one_item_at_a_time, (s_axis_tready_o && pc_d != PC_IDLE) |=> !s_axis_tready_o,
              "request taken while busy")
  `ASSERT_DEF(a_div_only_in_wait, div_busy |-> (pc_q == PC_DIV_WAIT),
              "divider running outside its wait step")
  `ASSERT_DEF(a_drain_empties, (uw.op == U_FIN_EMIT && out_free && !more) |=> (sp_q == '0),
              "stack not empty after drain")

endmodule

/* tb/tb_top.sv */
module tb_top;
  import rpn_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int unsigned RandomItems = 410;

  typedef struct packed {
    logic [DataW-1:0]   value;
    logic [DepthW-1:0]  depth;
    logic [StatusW-1:0] status;
    logic               last;
  } calc_result_t;

  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [DataW-1:0] operand;
  } calc_request_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid   = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata    = '0;  // operand
  logic [ActW-1:0]     s_axis_tuser    = '0;  // action
  logic                m_axis_tvalid;
  logic                m_axis_tready   = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;          // result_value, stack_depth, zero pad
  logic [StatusW-1:0]  m_axis_tuser;          // status
  logic                m_axis_tlast;

  calc_request_t requests_todo[$];
  calc_result_t  results_due[$];

  // predicted stack contents and entry count
  logic [DataW-1:0] calc_stack [Depth];
  int unsigned      calc_depth = 0;

  // rough depth seen by the stimulus generator, only to shape sequences
  int unsigned gen_depth = 0;
  int unsigned counted   = 0;
  int          errors    = 0;

  // driver pacing
  int burst_left = 0;
  int gap_left   = 0;

  // receiver pacing
  int       stall_left = 0;
  logic [7:0] phase_cnt = '0;
  logic       quiet     = 1'b0;

  rpn_stack_calculator #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] top_of_stack();
    if (calc_depth == 0) return '0;
    return calc_stack[calc_depth-1];
  endfunction

  function automatic void expect_result(logic [DataW-1:0] value, int unsigned depth,
                                        status_e status, logic last);
    calc_result_t r;
    r.value  = value;
    r.depth  = DepthW'(depth);
    r.status = status;
    r.last   = last;
    results_due.insert(results_due.size(), r);
  endfunction

  // truncating signed division on raw bit patterns, divisor nonzero
  function automatic logic [DataW-1:0] div_toward_zero(logic [DataW-1:0] a,
                                                       logic [DataW-1:0] b);
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic [DataW-1:0] q;
    ma = a[DataW-1] ? -a : a;
    mb = b[DataW-1] ? -b : b;
    q  = ma / mb;
    return (a[DataW-1] != b[DataW-1]) ? -q : q;
  endfunction

  function automatic void apply_request(calc_request_t rq);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] r;
    case (rq.act) inside
      ACT_PUSH: begin
        if (calc_depth >= Depth) begin
          expect_result(top_of_stack(), calc_depth, ST_OVER, 1'b1);
        end else begin
          calc_stack[calc_depth] = rq.operand;
          calc_depth++;
          expect_result(rq.operand, calc_depth, ST_OK, 1'b1);
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
        if (calc_depth < 2) begin
          expect_result(top_of_stack(), calc_depth, ST_UNDER, 1'b1);
        end else begin
          b = calc_stack[calc_depth-1];
          a = calc_stack[calc_depth-2];
          if (rq.act == ACT_DIV && b == '0) begin
            expect_result(b, calc_depth, ST_DIVZERO, 1'b1);
          end else begin
            case (rq.act)
              ACT_ADD: r = a + b;
              ACT_SUB: r = a - b;
              ACT_MUL: r = a * b;
              default: r = div_toward_zero(a, b);
            endcase
            calc_depth--;
            calc_stack[calc_depth-1] = r;
            expect_result(r, calc_depth, ST_OK, 1'b1);
          end
        end
      end
      ACT_FINISH: begin
        if (calc_depth == 0) begin
          expect_result('0, 0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < calc_depth; i++) begin
            expect_result(calc_stack[i], 0, ST_OK, i + 1 == calc_depth);
          end
        end
        calc_depth = 0;
      end
      default: ;  // unknown action, no result
    endcase
  endfunction

  function automatic void check_field(string name, logic [DataW-1:0] exp,
                                      logic [DataW-1:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp, act);
      errors++;
    end
  endfunction

  task automatic add_request(input logic [ActW-1:0] act, input logic [DataW-1:0] operand);
    calc_request_t rq;
    rq.act     = act;
    rq.operand = operand;
    requests_todo.insert(requests_todo.size(), rq);
    case (act) inside
      ACT_PUSH: begin
        if (gen_depth < Depth) gen_depth++;
        counted++;
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
        if (gen_depth >= 2) gen_depth--;
        counted++;
      end
      ACT_FINISH: begin
        gen_depth = 0;
        counted++;
      end
      default: ;
    endcase
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2:    v = DataW'($signed($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'hffff_ffff;
          3:       v = 32'h0000_0000;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  // sender: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    calc_request_t rq;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rq.act     = s_axis_tuser;
        rq.operand = s_axis_tdata;
        apply_request(rq);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (requests_todo.size() != 0) begin
          rq = requests_todo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= rq.act;
          s_axis_tdata  <= rq.operand;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern with quiet phases, and result check
  always @(posedge clk_i) begin
    calc_result_t exp;
    if (rst_ni) begin
      phase_cnt <= phase_cnt + 1'b1;
      if (phase_cnt == '0) quiet <= ($urandom_range(0, 3) == 0);
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left    <= $urandom_range(0, 29);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected result expected none actual %h %h %b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end else begin
          exp = results_due.pop_front();
          check_field("result_value", exp.value, m_axis_tdata[DataW-1:0]);
          check_field("stack_depth", DataW'(exp.depth), DataW'(m_axis_tdata[DataW +: DepthW]));
          check_field("status", DataW'(exp.status), DataW'(m_axis_tuser));
          check_field("last", DataW'(exp.last), DataW'(m_axis_tlast));
        end
      end
    end
  end

  initial begin
    int kind;
    // directed: empty-stack errors, extremes, overflowing divide, divide by zero
    add_request(ACT_ADD, 32'h0000_0005);
    add_request(ACT_FINISH, 32'hffff_ffff);
    add_request(ACT_PUSH, 32'h7fff_ffff);
    add_request(ACT_SUB, 32'h0000_0000);
    add_request(ACT_MUL, 32'h1234_5678);
    add_request(ACT_DIV, 32'h0000_0000);
    add_request(ACT_PUSH, 32'h8000_0000);
    add_request(ACT_PUSH, 32'hffff_ffff);
    add_request(ACT_DIV, 32'h0000_0000);
    add_request(ACT_PUSH, 32'h0000_0000);
    add_request(ACT_DIV, 32'hffff_ffff);
    add_request(ACT_MUL, 32'h0000_0000);
    add_request(ACT_PUSH, 32'h0000_0007);
    add_request(ACT_PUSH, 32'hffff_fffe);
    add_request(ACT_DIV, 32'h0000_0000);
    add_request(ACT_SUB, 32'h0000_0000);
    add_request(ACT_ADD, 32'h0000_0000);
    add_request(3'd6, 32'h0000_0001);
    add_request(3'd7, 32'h0000_0002);
    add_request(ACT_PUSH, 32'h7fff_ffff);
    add_request(ACT_ADD, 32'h0000_0000);
    add_request(ACT_FINISH, 32'h0000_0000);
    counted = 0;

    while (counted < RandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise
        repeat ($urandom_range(1, 3)) add_request(3'($urandom_range(0, 7)), $urandom);
      end else if (kind == 1) begin
        // fill near or past the top, maybe one operation, then drain
        repeat ($urandom_range(14, 18)) add_request(ACT_PUSH, pick_operand());
        if ($urandom_range(0, 1) == 0)
          add_request(3'($urandom_range(int'(ACT_ADD), int'(ACT_DIV))), $urandom);
        add_request(ACT_FINISH, $urandom);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if (gen_depth < 2 || $urandom_range(0, 2) == 0)
            add_request(ACT_PUSH, pick_operand());
          else
            add_request(3'($urandom_range(int'(ACT_ADD), int'(ACT_DIV))), $urandom);
        end
        if ($urandom_range(0, 4) != 0) add_request(ACT_FINISH, $urandom);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_todo.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (errors == 0 && results_due.size() == 0) begin
      $display("[rpn_stack_calculator] OK");
    end else begin
      $display("[rpn_stack_calculator] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[rpn_stack_calculator] ERROR");
    $finish;
  end

endmodule
